[hdl/thfd_pkg.sv]
// ----------------------------------------------------------------------------
// thfd_pkg
// Shared types and constants for the sensor frame decoder: beat structs,
// frame layout, CRC-16/MODBUS constants and result status codes.
// ----------------------------------------------------------------------------
package thfd_pkg;

    // Frame layout
    localparam int FRAME_LENGTH      = 8;
    localparam int CRC_COVERED_BYTES = 6;
    localparam int PAY_FIRST         = 2;
    localparam int PAY_DEPTH         = 5;
    localparam int POS_W             = $clog2(FRAME_LENGTH);
    localparam int PAY_IDX_W         = $clog2(PAY_DEPTH);

    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_LENGTH - 1);
    localparam logic [POS_W-1:0] POS_CRC_END = POS_W'(CRC_COVERED_BYTES);
    localparam logic [POS_W-1:0] POS_PAY_LO  = POS_W'(PAY_FIRST);
    localparam logic [POS_W-1:0] POS_PAY_HI  = POS_W'(PAY_FIRST + PAY_DEPTH - 1);

    // Payload store slots
    localparam logic [PAY_IDX_W-1:0] SLOT_HUM_HI  = PAY_IDX_W'(0);
    localparam logic [PAY_IDX_W-1:0] SLOT_HUM_LO  = PAY_IDX_W'(1);
    localparam logic [PAY_IDX_W-1:0] SLOT_TEMP_HI = PAY_IDX_W'(2);
    localparam logic [PAY_IDX_W-1:0] SLOT_TEMP_LO = PAY_IDX_W'(3);
    localparam logic [PAY_IDX_W-1:0] SLOT_CRC_LO  = PAY_IDX_W'(4);

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Temperature high byte: sign flag and magnitude mask
    localparam logic [7:0] TEMP_MAG_MASK = 8'h7F;
    localparam logic [7:0] TEMP_SIGN     = 8'h80;

    // Beat kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_READ = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
        logic [1:0]         frame_status;
    } t_out;

endpackage

[hdl/thfd_crc.sv]
// ----------------------------------------------------------------------------
// thfd_crc
// One-byte CRC-16/MODBUS update (reflected polynomial), fully unrolled.
// ----------------------------------------------------------------------------
module thfd_crc (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import thfd_pkg::*;

    // Eight shift/xor steps per byte
    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

[hdl/temp_humidity_frame_decode_unit.sv]
// Flow: a beat accepted into the input register is decoded from it; its result,
// if any, enters the output register when the beat leaves the input stage.
// Throughput: one beat per cycle; only a result beat waiting on a full output
// register holds the input stage. The byte CRC update is combinational logic.
// Reset: synchronous, active low; clears CRC to FFFF, position and held values.
// ----------------------------------------------------------------------------
// temp_humidity_frame_decode_unit
// Decodes eight-byte sensor replies, checks CRC-16/MODBUS over the first six
// bytes and holds humidity and temperature (tenths) from good frames. Read
// requests return the held values.
// ----------------------------------------------------------------------------
module temp_humidity_frame_decode_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  thfd_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output thfd_pkg::t_out o_out
);
    import thfd_pkg::*;

    // Input stage
    logic r_s1_valid;
    t_in  r_s1;

    // Frame state
    logic [15:0]      r_crc, n_crc;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_pay [PAY_DEPTH];
    logic [15:0]      r_held_hum, n_held_hum;
    logic [15:0]      r_held_temp, n_held_temp;

    // Output stage
    logic r_out_valid;
    t_out r_out;

    logic             out_free;
    logic             s1_res;
    logic             s1_adv;
    logic             s1_last;
    logic             pay_wr;
    logic [PAY_IDX_W-1:0] pay_idx;
    logic [15:0]      crc_in;
    logic [15:0]      crc_fed;
    logic [POS_W-1:0] pos_eff;
    logic [15:0]      rx_crc;
    logic [14:0]      temp_mag;
    logic [1:0]       res_status;

    // Handshake
    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_last     = (r_s1.kind == KIND_BYTE) && (pos_eff == POS_LAST);
    assign s1_res      = (r_s1.kind == KIND_READ) || s1_last;
    assign s1_adv      = r_s1_valid && (!s1_res || out_free);
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Frame start restarts count and CRC
    assign pos_eff = r_s1.frame_start ? '0 : r_pos;
    assign crc_in  = r_s1.frame_start ? CRC_INIT : r_crc;

    thfd_crc u_crc (
        .i_crc  (crc_in),
        .i_byte (r_s1.rx_byte),
        .o_crc  (crc_fed)
    );

    assign pay_wr  = (pos_eff >= POS_PAY_LO) && (pos_eff <= POS_PAY_HI);
    assign pay_idx = PAY_IDX_W'(pos_eff - POS_PAY_LO);
    assign rx_crc  = {r_s1.rx_byte, r_pay[SLOT_CRC_LO]};
    assign temp_mag = {r_pay[SLOT_TEMP_HI][6:0] & TEMP_MAG_MASK[6:0], r_pay[SLOT_TEMP_LO]};

    // Next state for a beat leaving the input stage
    always_comb begin
        n_crc       = r_crc;
        n_pos       = r_pos;
        n_held_hum  = r_held_hum;
        n_held_temp = r_held_temp;
        res_status  = ST_READ;
        if (r_s1.kind == KIND_BYTE) begin
            if (s1_last) begin
                n_pos = '0;
                n_crc = CRC_INIT;
                if (rx_crc == crc_in) begin
                    res_status = ST_OK;
                    n_held_hum = {r_pay[SLOT_HUM_HI], r_pay[SLOT_HUM_LO]};
                    if ((r_pay[SLOT_TEMP_HI] & TEMP_SIGN) != 8'h00) begin
                        n_held_temp = 16'h0000 - {1'b0, temp_mag};
                    end else begin
                        n_held_temp = {1'b0, temp_mag};
                    end
                end else begin
                    res_status = ST_BAD;
                end
            end else begin
                n_pos = pos_eff + POS_W'(1);
                n_crc = (pos_eff < POS_CRC_END) ? crc_fed : crc_in;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in;
        end
    end

    // Frame and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_pos       <= '0;
            r_held_hum  <= '0;
            r_held_temp <= '0;
        end else if (s1_adv) begin
            r_crc       <= n_crc;
            r_pos       <= n_pos;
            r_held_hum  <= n_held_hum;
            r_held_temp <= n_held_temp;
        end
    end

    // Payload bytes, no reset
    always_ff @(posedge i_clk) begin
        if (s1_adv && (r_s1.kind == KIND_BYTE) && pay_wr) begin
            r_pay[pay_idx] <= r_s1.rx_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv && s1_res) begin
            r_out.humidity_tenths    <= n_held_hum;
            r_out.temperature_tenths <= n_held_temp;
            r_out.frame_status       <= res_status;
        end
    end

    // A waiting result always matches the held values
    a_out_matches_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.humidity_tenths == r_held_hum) &&
                        (r_out.temperature_tenths == r_held_temp))
        else $error("output beat differs from held values");

    // End of frame returns count and CRC to their start values
    a_frame_end_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_last) |=> (r_pos == '0) && (r_crc == CRC_INIT))
        else $error("frame end did not rewind position and CRC");

    // Input stalls only behind a result blocked at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && s1_res && !out_free)
        else $error("input stalled without cause");

    // Held humidity changes only with an accepted frame loaded at the output
    a_held_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_hum != $past(r_held_hum)) |-> r_out_valid && (r_out.frame_status == ST_OK))
        else $error("held humidity changed without an accepted frame");

endmodule
